// ===== rtl/core/vmt_pkg.sv =====
// ----------------------------------------------------------------------------
// vmt_pkg
// shared constants and types of the vertex transform engine
// ----------------------------------------------------------------------------
`default_nettype none
package vmt_pkg;
	localparam int LANE_W    = 32;
	localparam int IN_DATA_W = 168;
	localparam int OUT_DATA_W = 224;

	typedef logic [1:0] cmd_t;

	localparam cmd_t CMD_LOAD   = 2'd0;
	localparam cmd_t CMD_VERTEX = 2'd1;
	localparam cmd_t CMD_NORMAL = 2'd2;
	localparam cmd_t CMD_NONE   = 2'd3;
endpackage
`default_nettype wire

// ===== rtl/core/vmt_matvec.sv =====
// ----------------------------------------------------------------------------
// vmt_matvec
// 4x4 matrix times vector, three stages: multiply, sum and round, saturate
// ----------------------------------------------------------------------------
`default_nettype none
module vmt_matvec #(
	parameter int OW        = 32,
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 en,
	input  wire logic                 in_valid,
	input  wire logic [3:0][OW-1:0]   in_vec,
	input  wire logic [SIDE_W-1:0]    in_side,
	input  wire logic                 wr_en,
	input  wire logic [3:0]           wr_idx,
	input  wire logic [OW-1:0]        wr_data,
	output logic                      out_valid,
	output logic [3:0][OW-1:0]        out_vec,
	output logic [SIDE_W-1:0]         out_side
);
	localparam int PW = 2 * OW;
	localparam int SW = 2 * OW + 3;
	localparam logic signed [SW-1:0] MAXV = {{(SW-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic signed [SW-1:0] MINV = ~MAXV;
	localparam logic signed [SW-1:0] RND  = SW'(1) <<< (FRAC_BITS - 1);

	logic [OW-1:0]          coef_q [16];
	logic signed [PW-1:0]   prod_s1 [16];
	logic                   valid_s1, valid_s2;
	logic [SIDE_W-1:0]      side_s1, side_s2;
	logic signed [SW-1:0]   sum_s2 [4];
	logic [3:0][OW-1:0]     sat_vec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) coef_q[i] <= '0;
		end else if (wr_en) begin
			coef_q[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			valid_s1  <= in_valid;
			valid_s2  <= valid_s1;
			out_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 4; r++) begin
				for (int c = 0; c < 4; c++) begin
					prod_s1[r*4+c] <= PW'($signed(coef_q[r*4+c]))
						* PW'($signed(in_vec[c]));
				end
			end
			side_s1 <= in_side;
			for (int r = 0; r < 4; r++) begin
				sum_s2[r] <= SW'(prod_s1[r*4]) + SW'(prod_s1[r*4+1])
					+ SW'(prod_s1[r*4+2]) + SW'(prod_s1[r*4+3]) + RND;
			end
			side_s2  <= side_s1;
			out_vec  <= sat_vec;
			out_side <= side_s2;
		end
	end

	always_comb begin
		logic signed [SW-1:0] sh;
		for (int r = 0; r < 4; r++) begin
			sh = sum_s2[r] >>> FRAC_BITS;
			if (sh > MAXV) sat_vec[r] = MAXV[OW-1:0];
			else if (sh < MINV) sat_vec[r] = MINV[OW-1:0];
			else sat_vec[r] = sh[OW-1:0];
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/vmt_div.sv =====
// ----------------------------------------------------------------------------
// vmt_div
// pipelined restoring divider, three numerators over one divisor, one bit
// per stage, with saturation and zero divisor handling
// ----------------------------------------------------------------------------
`default_nettype none
module vmt_div #(
	parameter int OW        = 32,
	parameter int FRAC_BITS = 16,
	parameter int SIDE_W    = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [2:0][OW-1:0] in_num,
	input  wire logic [OW-1:0]      in_den,
	input  wire logic [SIDE_W-1:0]  in_side,
	output logic                    out_valid,
	output logic [2:0][OW-1:0]      out_q,
	output logic                    out_err,
	output logic [SIDE_W-1:0]       out_side
);
	localparam int QB = OW + FRAC_BITS;
	localparam logic [QB-1:0] LIM_POS = {{(QB-OW+1){1'b0}}, {(OW-1){1'b1}}};
	localparam logic [QB-1:0] LIM_NEG = LIM_POS + QB'(1);
	localparam logic [OW-1:0] MAXV = {1'b0, {(OW-1){1'b1}}};
	localparam logic [OW-1:0] MINV = ~MAXV;

	logic                    valid_s [QB+1];
	logic [SIDE_W-1:0]       side_s  [QB+1];
	logic [OW-1:0]           den_s   [QB+1];
	logic                    zero_s  [QB+1];
	logic [2:0]              neg_s   [QB+1];
	logic [2:0]              pos_s   [QB+1];
	logic [2:0][OW:0]        rem_s   [QB+1];
	logic [2:0][QB-1:0]      num_s   [QB+1];
	logic [2:0][QB-1:0]      quo_s   [QB+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		logic [OW-1:0] mag;
		logic [OW-1:0] dmag;
		if (en) begin
			dmag = in_den[OW-1] ? (~in_den + OW'(1)) : in_den;
			side_s[0] <= in_side;
			den_s[0]  <= dmag;
			zero_s[0] <= (in_den == '0);
			for (int i = 0; i < 3; i++) begin
				mag = in_num[i][OW-1] ? (~in_num[i] + OW'(1)) : in_num[i];
				neg_s[0][i] <= in_num[i][OW-1] ^ in_den[OW-1];
				pos_s[0][i] <= ~in_num[i][OW-1];
				rem_s[0][i] <= '0;
				num_s[0][i] <= {mag, {FRAC_BITS{1'b0}}};
				quo_s[0][i] <= '0;
			end
		end
	end

	for (genvar k = 1; k <= QB; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k] <= 1'b0;
			end else if (en) begin
				valid_s[k] <= valid_s[k-1];
			end
		end

		always_ff @(posedge clk) begin
			logic [OW:0] trial;
			if (en) begin
				side_s[k] <= side_s[k-1];
				den_s[k]  <= den_s[k-1];
				zero_s[k] <= zero_s[k-1];
				neg_s[k]  <= neg_s[k-1];
				pos_s[k]  <= pos_s[k-1];
				for (int i = 0; i < 3; i++) begin
					trial = {rem_s[k-1][i][OW-1:0], num_s[k-1][i][QB-1]};
					num_s[k][i] <= {num_s[k-1][i][QB-2:0], 1'b0};
					if (trial >= {1'b0, den_s[k-1]}) begin
						rem_s[k][i] <= trial - {1'b0, den_s[k-1]};
						quo_s[k][i] <= {quo_s[k-1][i][QB-2:0], 1'b1};
					end else begin
						rem_s[k][i] <= trial;
						quo_s[k][i] <= {quo_s[k-1][i][QB-2:0], 1'b0};
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= valid_s[QB];
		end
	end

	always_ff @(posedge clk) begin
		logic [QB-1:0] q;
		if (en) begin
			out_side <= side_s[QB];
			out_err  <= zero_s[QB];
			for (int i = 0; i < 3; i++) begin
				q = quo_s[QB][i];
				if (zero_s[QB]) out_q[i] <= pos_s[QB][i] ? MAXV : MINV;
				else if (!neg_s[QB][i]) out_q[i] <= (q > LIM_POS) ? MAXV : q[OW-1:0];
				else out_q[i] <= (q > LIM_NEG) ? MINV : (~q[OW-1:0] + OW'(1));
			end
		end
	end
endmodule
`default_nettype wire

// ===== rtl/core/vertex_mvp_transform_top.sv =====
// ----------------------------------------------------------------------------
// vertex_mvp_transform_top
// vertex transform engine: model-view product, projection product and
// perspective divide
// ----------------------------------------------------------------------------
// one request is taken per clock unless the output stalls; a vertex or
// normal passes the input register, model-view and projection products,
// the one-bit-per-stage divider (OW = min(WORD_WIDTH, 32) bit words) and
// the output register. load requests write the model-view matrix as they
// pass the first product stage, the projection matrix as they pass the
// second, so results follow request order. both matrices reset to zero.
// ----------------------------------------------------------------------------
`default_nettype none
module vertex_mvp_transform_top
	import vmt_pkg::*;
#(
	parameter int FRAC_BITS  = 16,
	parameter int WORD_WIDTH = 32
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// entry_index, coeff_value, in_x, in_y, in_z, in_w, zero fill
	input  wire logic [IN_DATA_W-1:0]  s_tdata,
	// cmd, matrix_sel
	input  wire logic [2:0]            s_tuser,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// view_x, view_y, view_z, view_w, screen_x, screen_y, screen_z
	output logic [OUT_DATA_W-1:0]      m_tdata,
	// divide_error
	output logic                       m_tuser
);
	localparam int OW = (WORD_WIDTH < LANE_W) ? WORD_WIDTH : LANE_W;
	localparam int A_SIDE_W = 7 + OW;
	localparam int B_SIDE_W = 2 + 4 * OW;

	logic               en;
	logic               valid_s0;
	cmd_t               cmd_s0;
	logic               sel_s0;
	logic [3:0]         idx_s0;
	logic [OW-1:0]      coeff_s0;
	logic [3:0][OW-1:0] vec_s0;

	logic               a_valid;
	logic [3:0][OW-1:0] a_vec;
	logic [A_SIDE_W-1:0] a_side;
	cmd_t               a_cmd;
	logic               a_sel;
	logic [3:0]         a_idx;
	logic [OW-1:0]      a_coeff;

	logic               b_valid;
	logic [3:0][OW-1:0] b_vec;
	logic [B_SIDE_W-1:0] b_side;
	cmd_t               b_cmd;

	logic               d_valid;
	logic [2:0][OW-1:0] d_q;
	logic               d_err;
	logic [B_SIDE_W-1:0] d_side;
	cmd_t               d_cmd;
	logic [3:0][OW-1:0] d_view;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s0 <= 1'b0;
		end else if (en) begin
			valid_s0 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cmd_s0   <= s_tuser[1:0];
			sel_s0   <= s_tuser[2];
			idx_s0   <= s_tdata[3:0];
			coeff_s0 <= s_tdata[4 +: OW];
			for (int i = 0; i < 4; i++) vec_s0[i] <= s_tdata[36 + 32*i +: OW];
		end
	end

	vmt_matvec #(.OW(OW), .FRAC_BITS(FRAC_BITS), .SIDE_W(A_SIDE_W)) u_mv (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(valid_s0), .in_vec(vec_s0),
		.in_side({coeff_s0, idx_s0, sel_s0, cmd_s0}),
		.wr_en(en && valid_s0 && cmd_s0 == CMD_LOAD && !sel_s0),
		.wr_idx(idx_s0), .wr_data(coeff_s0),
		.out_valid(a_valid), .out_vec(a_vec), .out_side(a_side)
	);

	assign {a_coeff, a_idx, a_sel, a_cmd} = a_side;

	vmt_matvec #(.OW(OW), .FRAC_BITS(FRAC_BITS), .SIDE_W(B_SIDE_W)) u_proj (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(a_valid), .in_vec(a_vec),
		.in_side({a_vec, a_cmd}),
		.wr_en(en && a_valid && a_cmd == CMD_LOAD && a_sel),
		.wr_idx(a_idx), .wr_data(a_coeff),
		.out_valid(b_valid), .out_vec(b_vec), .out_side(b_side)
	);

	assign b_cmd = b_side[1:0];

	vmt_div #(.OW(OW), .FRAC_BITS(FRAC_BITS), .SIDE_W(B_SIDE_W)) u_div (
		.clk(clk), .arst_n(arst_n), .en(en),
		.in_valid(b_valid && (b_cmd == CMD_VERTEX || b_cmd == CMD_NORMAL)),
		.in_num(b_vec[2:0]), .in_den(b_vec[3]), .in_side(b_side),
		.out_valid(d_valid), .out_q(d_q), .out_err(d_err), .out_side(d_side)
	);

	assign {d_view, d_cmd} = d_side;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= d_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				m_tdata[32*i +: 32] <= LANE_W'($signed(d_view[i]));
			end
			for (int i = 0; i < 3; i++) begin
				m_tdata[128 + 32*i +: 32] <= (d_cmd == CMD_NORMAL) ? '0
					: LANE_W'($signed(d_q[i]));
			end
			m_tuser <= (d_cmd == CMD_NORMAL) ? 1'b0 : d_err;
		end
	end
endmodule
`default_nettype wire
